// ===== design/scq_pkg.sv =====
// Shared constants, codes and types for the sparse CAR quadratic form block.
// Used by the channel interfaces, the iterative multiplier and the top level.
// Depends on nothing.
package scq_pkg;

  localparam int Sites     = 1024;
  localparam int SiteAw    = $clog2(Sites);
  localparam int IdxW      = 10;
  localparam int ValW      = 24;
  localparam int WsumW     = 16;
  localparam int RhoW      = 17;
  localparam int AccW      = 64;
  localparam int PdW       = 2 * ValW;
  localparam int FW        = 36;
  localparam int ProdW     = AccW + FW;
  localparam int MulDigitW = 16;
  localparam int MulSteps  = AccW / MulDigitW;
  localparam int MulCntW   = $clog2(MulSteps);
  localparam int FracShift = 24;
  localparam int WsumFrac  = 8;
  localparam int OneQ16    = 65536;

  typedef enum logic [1:0] {
    FN_SITE = 2'd0,
    FN_TRIP = 2'd1,
    FN_FIN  = 2'd2
  } scq_func_e;

  typedef enum logic [1:0] {
    OP_SITE,
    OP_TRIP,
    OP_FIN
  } scq_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIP_RD,
    ST_ISSUE,
    ST_MUL,
    ST_SCALE,
    ST_ACC
  } scq_state_e;

  typedef struct packed {
    logic                   start;
    logic signed [AccW-1:0] a;
    logic signed [FW-1:0]   b;
  } scq_mul_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             neg;
    logic [ProdW-1:0] mag;
  } scq_mul_rsp_t;

endpackage

// ===== design/scq_if.sv =====
// Valid/ready channel interfaces: item input, result output and the rho write port.
// Depends on scq_pkg for the field widths.
interface scq_in_if import scq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             func;
  logic [IdxW-1:0]        site_index;
  logic signed [ValW-1:0] phi_value;
  logic signed [ValW-1:0] delta_value;
  logic [WsumW-1:0]       neighbor_weight_sum;
  logic [IdxW-1:0]        triplet_row;
  logic [IdxW-1:0]        triplet_col;
  logic [WsumW-1:0]       triplet_weight;

  modport source (
    output valid, func, site_index, phi_value, delta_value, neighbor_weight_sum,
           triplet_row, triplet_col, triplet_weight,
    input  ready
  );
  modport sink (
    input  valid, func, site_index, phi_value, delta_value, neighbor_weight_sum,
           triplet_row, triplet_col, triplet_weight,
    output ready
  );
endinterface

interface scq_out_if import scq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [AccW-1:0] quadratic_form;
  logic                   overflow;

  modport source (output valid, quadratic_form, overflow, input ready);
  modport sink (input valid, quadratic_form, overflow, output ready);
endinterface

interface scq_cfg_if import scq_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RhoW-1:0] rho;

  modport source (output valid, rho, input ready);
  modport sink (input valid, rho, output ready);
endinterface

// ===== design/scq_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing.
module scq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/scq_mul.sv =====
// Iterative sign-magnitude multiplier, 64 by 36 bits, one 16-bit digit of A per cycle.
// Depends on scq_pkg for widths and the request/response structs.
module scq_mul import scq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  scq_mul_req_t req_i,
  output scq_mul_rsp_t rsp_o
);

  localparam int PpW  = MulDigitW + FW;
  localparam int SumW = PpW + 1;
  localparam int HiW  = SumW - MulDigitW;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [MulCntW-1:0] cnt_q, cnt_d;
  logic [AccW-1:0]    a_q, a_d;
  logic [FW-1:0]      b_q, b_d;
  logic               neg_q, neg_d;
  logic [HiW-1:0]     hi_q, hi_d;
  logic [AccW-1:0]    lo_q, lo_d;

  logic [AccW-1:0] a_raw;
  logic [FW-1:0]   b_raw;
  logic [PpW-1:0]  pp;
  logic [SumW-1:0] sum;

  always_comb begin
    a_raw  = req_i.a;
    b_raw  = req_i.b;
    pp     = PpW'(a_q[MulDigitW-1:0]) * PpW'(b_q);
    sum    = SumW'(hi_q) + SumW'(pp);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    neg_d  = neg_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (req_i.start) begin
      // Magnitudes; the most negative A maps to 2^63, which still fits.
      a_d    = a_raw[AccW-1] ? (~a_raw + 1'b1) : a_raw;
      b_d    = b_raw[FW-1] ? (~b_raw + 1'b1) : b_raw;
      neg_d  = a_raw[AccW-1] ^ b_raw[FW-1];
      hi_d   = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      lo_d  = {sum[MulDigitW-1:0], lo_q[AccW-1:MulDigitW]};
      hi_d  = sum[SumW-1:MulDigitW];
      a_d   = a_q >> MulDigitW;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MulCntW'(MulSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    neg_q <= neg_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.neg  = neg_q;
  assign rsp_o.mag  = ProdW'({hi_q, lo_q});

endmodule

// ===== design/sparse_car_quadratic_form_top.sv =====
// Top level of the sparse CAR quadratic form accumulator: sequencer, sums and stores.
// Depends on scq_pkg, the scq_if interfaces, scq_ram and scq_mul.
//
//   Channel   Dir   Handshake       Beat carries
//   cfg_i     in    valid/ready     rho, unsigned Q1.16
//   in_i      in    valid/ready     func, site and triplet fields
//   out_o     out   valid/ready     quadratic_form (Q31.32), overflow
//
// Input beats are handled one at a time: after a beat is accepted, the next one waits until
// its product has passed through the shared multiplier, which consumes one 16-bit digit of
// its 64-bit operand per cycle, and has been accumulated. Beats that carry an unknown
// func code or an out-of-range site or triplet index are accepted and dropped.
// Reset is asynchronous and active low; it clears rho, both sums and the overflow flag.
// The phi and delta stores are not cleared, so every site must be loaded before a
// triplet names it. A finish beat waits in its last step while the result register
// still holds an untaken result; the configuration port is always ready.
module sparse_car_quadratic_form_top import scq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  scq_cfg_if.sink   cfg_i,
  scq_in_if.sink    in_i,
  scq_out_if.source out_o
);

  localparam int QW = ProdW + 1 - FracShift;
  localparam logic [ProdW:0]   RndHalf = (ProdW + 1)'(1) << (FracShift - 1);
  localparam logic [AccW-1:0]  MinBits = {1'b1, {(AccW - 1){1'b0}}};
  localparam logic [AccW-1:0]  MaxBits = {1'b0, {(AccW - 1){1'b1}}};

  // Configuration register.
  logic [RhoW-1:0] rho_q, rho_d;

  // Control state.
  scq_state_e      state_q, state_d;
  scq_op_e         op_q, op_d;
  logic [AccW-1:0] diag_q, diag_d;
  logic [AccW-1:0] off_q, off_d;
  logic            ovf_q, ovf_d;
  logic            out_valid_q, out_valid_d;

  // Datapath registers.
  logic signed [PdW-1:0] pd_q, pd_d;
  logic signed [FW-1:0]  f_q, f_d;
  logic [WsumW-1:0]      w_q, w_d;
  logic [AccW-1:0]       term_q, term_d;
  logic                  tsat_q, tsat_d;
  logic [AccW-1:0]       qf_q, qf_d;
  logic                  oflag_q, oflag_d;

  scq_func_e    func_e;
  logic         in_ready;
  logic         site_ok, trip_ok;
  logic         ram_we, ram_re;
  logic [ValW-1:0] phi_rd, delta_rd;
  logic         mul_start;
  scq_mul_req_t mul_req;
  scq_mul_rsp_t mul_rsp;

  logic [RhoW+WsumW-1:0]  rw;
  logic signed [RhoW:0]   om;
  logic signed [FW-1:0]   f_site;

  logic [ProdW:0]  rnd;
  logic [QW-1:0]   q;
  logic [AccW-1:0] lim, qv, rv, exact;
  logic            rsat;
  logic [AccW-1:0] scale_term;
  logic            scale_sat;

  logic [AccW-1:0] add_a, add_s, add_res;
  logic            add_ovf;

  // The rho register takes every write beat.
  assign cfg_i.ready = 1'b1;
  assign rho_d       = cfg_i.valid ? cfg_i.rho : rho_q;

  assign func_e  = scq_func_e'(in_i.func);
  assign site_ok = int'(in_i.site_index) < Sites;
  assign trip_ok = (int'(in_i.triplet_row) < Sites) && (int'(in_i.triplet_col) < Sites);

  // The two stores. A site beat writes both at acceptance; a triplet beat reads phi at its
  // row and delta at its column. Items are handled one at a time, so a write always lands
  // before any later read and no forwarding path is needed.
  scq_ram #(.Width(ValW), .Depth(Sites)) u_phi_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(SiteAw'(in_i.site_index)),
    .wdata_i(in_i.phi_value),
    .re_i   (ram_re),
    .raddr_i(SiteAw'(in_i.triplet_row)),
    .rdata_o(phi_rd)
  );

  scq_ram #(.Width(ValW), .Depth(Sites)) u_delta_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(SiteAw'(in_i.site_index)),
    .wdata_i(in_i.delta_value),
    .re_i   (ram_re),
    .raddr_i(SiteAw'(in_i.triplet_col)),
    .rdata_o(delta_rd)
  );

  // One multiplier is shared by all three item kinds. Operand A is phi*delta for site and
  // triplet beats and the off-diagonal sum on finish; operand B is the diagonal factor,
  // the pair weight or rho, always staged in f_q.
  assign mul_req.start = mul_start;
  assign mul_req.a     = (op_q == OP_FIN) ? off_q : AccW'(pd_q);
  assign mul_req.b     = f_q;

  scq_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  // Diagonal factor: rho*wsum + (1 - rho), aligned to Q.24. It goes negative when rho
  // exceeds one and the weight sum is below one, so it is kept signed.
  always_comb begin
    rw     = (RhoW + WsumW)'(rho_q) * (RhoW + WsumW)'(in_i.neighbor_weight_sum);
    om     = (RhoW + 1)'(OneQ16) - $signed({1'b0, rho_q});
    f_site = $signed(FW'(rw)) + FW'($signed({om, {WsumFrac{1'b0}}}));
  end

  // Rescaling of the magnitude product: round half away from zero from Q.56 to Q.32,
  // saturate against the limit of the result's sign, then restore the sign.
  always_comb begin
    rnd   = (ProdW + 1)'(mul_rsp.mag) + RndHalf;
    q     = rnd[ProdW:FracShift];
    lim   = mul_rsp.neg ? MinBits : MaxBits;
    rsat  = (|q[QW-1:AccW]) || (q[AccW-1:0] > lim);
    qv    = rsat ? lim : q[AccW-1:0];
    rv    = mul_rsp.neg ? (~qv + 1'b1) : qv;
    exact = mul_rsp.neg ? (~mul_rsp.mag[AccW-1:0] + 1'b1) : mul_rsp.mag[AccW-1:0];
    case (op_q)
      OP_TRIP: begin
        // The triplet product is exact and always fits in 64 bits.
        scale_term = exact;
        scale_sat  = 1'b0;
      end
      OP_FIN: begin
        // Finish subtracts rho times the off-diagonal sum; negating the most negative
        // value saturates.
        if (rv == MinBits) begin
          scale_term = MaxBits;
          scale_sat  = 1'b1;
        end else begin
          scale_term = ~rv + 1'b1;
          scale_sat  = rsat;
        end
      end
      default: begin
        scale_term = rv;
        scale_sat  = rsat;
      end
    endcase
  end

  // Saturating accumulate, shared by both sums and the final difference.
  always_comb begin
    add_a   = (op_q == OP_TRIP) ? off_q : diag_q;
    add_s   = add_a + term_q;
    add_ovf = (add_a[AccW-1] == term_q[AccW-1]) && (add_s[AccW-1] != add_a[AccW-1]);
    add_res = add_ovf ? (add_a[AccW-1] ? MinBits : MaxBits) : add_s;
  end

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    pd_d          = pd_q;
    f_d           = f_q;
    w_d           = w_q;
    term_d        = term_q;
    tsat_d        = tsat_q;
    diag_d        = diag_q;
    off_d         = off_q;
    ovf_d         = ovf_q;
    qf_d          = qf_q;
    oflag_d       = oflag_q;
    out_valid_d   = out_valid_q;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    mul_start     = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          case (func_e)
            FN_SITE: begin
              if (site_ok) begin
                ram_we  = 1'b1;
                pd_d    = PdW'(in_i.phi_value) * PdW'(in_i.delta_value);
                f_d     = f_site;
                op_d    = OP_SITE;
                state_d = ST_ISSUE;
              end
            end
            FN_TRIP: begin
              if (trip_ok) begin
                ram_re  = 1'b1;
                w_d     = in_i.triplet_weight;
                op_d    = OP_TRIP;
                state_d = ST_TRIP_RD;
              end
            end
            FN_FIN: begin
              f_d     = $signed(FW'(rho_q));
              op_d    = OP_FIN;
              state_d = ST_ISSUE;
            end
            default: begin
              // Unknown function code: the beat is dropped.
            end
          endcase
        end
      end
      ST_TRIP_RD: begin
        pd_d    = PdW'($signed(phi_rd)) * PdW'($signed(delta_rd));
        f_d     = $signed(FW'(w_q));
        state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        mul_start = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        term_d  = scale_term;
        tsat_d  = scale_sat;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        case (op_q)
          OP_SITE: begin
            diag_d  = add_res;
            ovf_d   = ovf_q | tsat_q | add_ovf;
            state_d = ST_IDLE;
          end
          OP_TRIP: begin
            off_d   = add_res;
            ovf_d   = ovf_q | add_ovf;
            state_d = ST_IDLE;
          end
          OP_FIN: begin
            // Load the result register once it is free, then clear the sums.
            if (!out_valid_q || out_o.ready) begin
              out_valid_d = 1'b1;
              qf_d        = {add_res[AccW-1], add_res[AccW-1:1]};
              oflag_d     = ovf_q | tsat_q | add_ovf;
              diag_d      = '0;
              off_d       = '0;
              ovf_d       = 1'b0;
              state_d     = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rho_q       <= '0;
      state_q     <= ST_IDLE;
      op_q        <= OP_SITE;
      diag_q      <= '0;
      off_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rho_q       <= rho_d;
      state_q     <= state_d;
      op_q        <= op_d;
      diag_q      <= diag_d;
      off_q       <= off_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pd_q    <= pd_d;
    f_q     <= f_d;
    w_q     <= w_d;
    term_q  <= term_d;
    tsat_q  <= tsat_d;
    qf_q    <= qf_d;
    oflag_q <= oflag_d;
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.quadratic_form = qf_q;
  assign out_o.overflow       = oflag_q;

  // The multiplier is only started when it has finished its previous product.
  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  // A finished product is only ever seen by the sequencer while it waits for one.
  a_mul_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == ST_MUL))
    else $error("multiplier finished outside the wait state");

  // A new result comes only from the last step of a finish beat, and the sums are
  // cleared at the same edge.
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q == ST_ACC && op_q == OP_FIN)
                            && diag_q == '0 && off_q == '0 && !ovf_q))
    else $error("result appeared without a finish step");

  // The stores are never written and read in the same cycle.
  a_ram_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("store written and read together");

endmodule
